[design/lstc_pkg.sv]
// Shared types and constants for the leap-second time converter.
`default_nettype none

package lstc_pkg;

  // Table depth and the index and count widths derived from it.
  localparam int MAX_LEAPS = 32;
  localparam int ADDR_W    = (MAX_LEAPS > 1) ? $clog2(MAX_LEAPS) : 1;
  localparam int CNT_W     = $clog2(MAX_LEAPS + 1);

  localparam logic [31:0] DAY_SECONDS = 32'd86400;
  localparam logic [30:0] NS_PER_SEC  = 31'd1_000_000_000;

  // Item action codes.
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_R2P  = 2'd1;
  localparam logic [1:0] ACT_P2R  = 2'd2;

  // Leap state codes.
  localparam logic signed [2:0] LS_NONE      = 3'sd0;
  localparam logic signed [2:0] LS_INS_NEXT  = 3'sd1;
  localparam logic signed [2:0] LS_INSERTING = 3'sd2;
  localparam logic signed [2:0] LS_DEL_NEXT  = -3'sd1;
  localparam logic signed [2:0] LS_DELETED   = -3'sd2;

  // Clock status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INS      = 3'd1;
  localparam logic [2:0] ST_DEL      = 3'd2;
  localparam logic [2:0] ST_IN_LEAP  = 3'd3;
  localparam logic [2:0] ST_WAIT     = 3'd4;

  // One leap table entry as stored in the table memory.
  typedef struct packed {
    logic [31:0]        transition;
    logic [31:0]        posix_leap;
    logic [31:0]        day_start;
    logic               is_insert;
    logic signed [7:0]  offset;
  } entry_t;

  // Verdict of the entry evaluator on one table entry.
  typedef struct packed {
    logic       match_hit;
    logic       stat_hit;
    logic [2:0] stat_code;
  } eval_t;

endpackage

`default_nettype wire

[design/lstc_ram.sv]
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module lstc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/lstc_entry_eval.sv]
// Compare unit that judges one table entry against the timestamp under conversion.
`default_nettype none

module lstc_entry_eval (
  input  wire logic             fwd,
  input  wire logic [31:0]      t,
  input  wire lstc_pkg::entry_t entry,
  output lstc_pkg::eval_t       verdict
);

  logic [32:0] t_w;
  logic [32:0] tr_w;

  assign t_w  = {1'b0, t};
  assign tr_w = {1'b0, entry.transition};

  always_comb begin
    verdict.match_hit = fwd ? (t >= entry.transition) : (t >= entry.posix_leap);
    verdict.stat_hit  = 1'b0;
    verdict.stat_code = lstc_pkg::ST_OK;
    // The status search only runs for right-to-POSIX items.
    if (fwd) begin
      if (entry.is_insert) begin
        if (t_w > tr_w + 33'd2) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_OK;
        end else if (t_w > tr_w + 33'd1) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_WAIT;
        end else if (t_w >= tr_w) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_IN_LEAP;
        end else if (t >= entry.day_start) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_INS;
        end
      end else begin
        if (t_w > tr_w + 33'd1) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_OK;
        end else if (t_w > tr_w) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_WAIT;
        end else if (t >= entry.day_start) begin
          verdict.stat_hit  = 1'b1;
          verdict.stat_code = lstc_pkg::ST_DEL;
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/leap_second_time_converter_top.sv]
// Top level of the leap-second table and right/POSIX time converter.
`default_nettype none

// This block keeps a table of up to lstc_pkg::MAX_LEAPS leap seconds and converts
// timestamps between leap-counting (right) time and POSIX time. An item is taken
// when start is high while busy is low, and every item produces exactly one result,
// shown for a single cycle with done high; the receiver has no way to stall it, so
// it must capture the result in that cycle. A load item (action 0) appends one
// entry, and its result arrives in the cycle after the item is taken, with
// table_overflow set when the table was full and the entry was dropped. Setting
// restart_table empties the table before the entry is stored. A conversion item
// (action 1 right to POSIX, action 2 POSIX to right) walks the table from the
// newest entry backward through one compare unit, one entry per cycle, reading the
// table memory one entry ahead. The walk stops as soon as both the matching entry
// and, for right to POSIX, the status entry are known. Halved or doubled
// nanoseconds smear the leap second, and a doubled value is normalized by
// subtracting one second per cycle. An unused action code returns an all-zero
// result. The table memory holds no reset value, but only entries written since
// the last restart are ever read.
module leap_second_time_converter_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         action,
  input  wire logic [31:0]        seconds,
  input  wire logic [29:0]        nanoseconds,
  input  wire logic signed [7:0]  leap_offset,
  input  wire logic               restart_table,
  output logic                    done,
  output logic [31:0]             out_seconds,
  output logic [29:0]             out_nanoseconds,
  output logic signed [2:0]       leap_state,
  output logic [2:0]              time_status,
  output logic                    table_overflow
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_CALC,
    S_NORM
  } state_t;

  state_t state;

  // Latched item fields.
  logic [1:0]  act;
  logic [31:0] t_in;
  logic [29:0] ns_in;

  // Table bookkeeping.
  logic [lstc_pkg::CNT_W-1:0] count;
  logic signed [7:0]          prev_off;

  // Walk state.
  logic [lstc_pkg::ADDR_W-1:0] cur_idx;
  logic                        match_found;
  lstc_pkg::entry_t            match_ent;
  logic                        stat_found;
  logic [2:0]                  stat_code;

  // Nanosecond work register, one bit wider than the port for doubled values.
  logic [30:0] rns;
  logic        dbl;

  // Load path signals.
  logic                       accept;
  logic                       is_load;
  logic [lstc_pkg::CNT_W-1:0] cnt_eff;
  logic signed [7:0]          prev_eff;
  logic                       fits;
  logic                       ins_new;
  lstc_pkg::entry_t           new_ent;

  // Memory and compare unit.
  logic [lstc_pkg::CNT_W-1:0]  cnt_m1;
  logic [lstc_pkg::ADDR_W-1:0] rd_addr;
  logic [lstc_pkg::ADDR_W-1:0] wr_addr;
  logic                        ram_we;
  logic [$bits(lstc_pkg::entry_t)-1:0] ram_rdata;
  lstc_pkg::entry_t            cur_ent;
  lstc_pkg::eval_t             verdict;
  logic                        fwd;
  logic                        walk_end;

  // Conversion arithmetic.
  logic [31:0]       chg;
  logic [31:0]       t_m1;
  logic [31:0]       calc_sec;
  logic [30:0]       calc_rns;
  logic signed [2:0] calc_ls;
  logic              calc_dbl;
  logic [30:0]       ns_half;
  logic [30:0]       ns_dbl;
  logic [30:0]       ns_smear;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_load = (action == lstc_pkg::ACT_LOAD);
  assign fwd     = (act == lstc_pkg::ACT_R2P);

  // A load with restart sees an empty table, so it always fits.
  assign cnt_eff  = restart_table ? '0 : count;
  assign prev_eff = restart_table ? 8'sd0 : prev_off;
  assign fits     = (cnt_eff < lstc_pkg::CNT_W'(lstc_pkg::MAX_LEAPS));
  assign ins_new  = (leap_offset > prev_eff);
  assign wr_addr  = cnt_eff[lstc_pkg::ADDR_W-1:0];
  assign ram_we   = accept && is_load && fits;

  always_comb begin
    new_ent.is_insert  = ins_new;
    new_ent.transition = seconds - {31'd0, ins_new};
    new_ent.posix_leap = seconds - {31'd0, ins_new}
                         - {{24{prev_eff[7]}}, prev_eff};
    new_ent.day_start  = seconds - lstc_pkg::DAY_SECONDS + {31'd0, !ins_new};
    new_ent.offset     = leap_offset;
  end

  // The read address runs one entry ahead of the entry being judged.
  assign cnt_m1  = count - 1'b1;
  assign rd_addr = (state == S_IDLE) ? cnt_m1[lstc_pkg::ADDR_W-1:0] : cur_idx - 1'b1;

  lstc_ram #(
    .WIDTH ($bits(lstc_pkg::entry_t)),
    .DEPTH (lstc_pkg::MAX_LEAPS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (new_ent),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign cur_ent = lstc_pkg::entry_t'(ram_rdata);

  lstc_entry_eval u_eval (
    .fwd     (fwd),
    .t       (t_in),
    .entry   (cur_ent),
    .verdict (verdict)
  );

  // The walk ends once both searches have an answer or the oldest entry is judged.
  assign walk_end = ((match_found || verdict.match_hit) && (stat_found || verdict.stat_hit))
                    || (cur_idx == '0);

  // Result arithmetic on the matched entry.
  assign chg      = {{24{match_ent.offset[7]}}, match_ent.offset};
  assign t_m1     = t_in - 32'd1;
  assign ns_half  = {2'b00, ns_in[29:1]};
  assign ns_dbl   = {ns_in, 1'b0};
  assign ns_smear = ({1'b0, ns_in} + lstc_pkg::NS_PER_SEC) >> 1;

  always_comb begin
    calc_sec = t_in;
    calc_rns = {1'b0, ns_in};
    calc_ls  = lstc_pkg::LS_NONE;
    calc_dbl = 1'b0;
    if (match_found) begin
      if (fwd) begin
        priority if (match_ent.is_insert && t_m1 == match_ent.transition) begin
          calc_sec = t_in - chg;
          calc_ls  = lstc_pkg::LS_INSERTING;
          calc_rns = ns_smear;
        end else if (match_ent.is_insert && t_in == match_ent.transition) begin
          calc_sec = t_in - chg + 32'd1;
          calc_ls  = lstc_pkg::LS_INS_NEXT;
          calc_rns = ns_half;
        end else if (!match_ent.is_insert && t_in == match_ent.transition) begin
          calc_sec = t_in - chg - 32'd1;
          calc_ls  = lstc_pkg::LS_DEL_NEXT;
          calc_rns = ns_dbl;
          calc_dbl = 1'b1;
        end else begin
          calc_sec = t_in - chg;
        end
      end else begin
        priority if (match_ent.is_insert && t_in == match_ent.posix_leap) begin
          calc_sec = t_in + chg - 32'd1;
          calc_ls  = lstc_pkg::LS_INS_NEXT;
          calc_rns = ns_dbl;
          calc_dbl = 1'b1;
        end else if (!match_ent.is_insert && t_in == match_ent.posix_leap) begin
          calc_sec = t_in + chg + 32'd1;
          calc_ls  = lstc_pkg::LS_DEL_NEXT;
          calc_rns = ns_half;
        end else if (!match_ent.is_insert && t_m1 == match_ent.posix_leap) begin
          calc_sec = t_in + chg;
          calc_ls  = lstc_pkg::LS_DELETED;
          calc_rns = ns_smear;
        end else begin
          calc_sec = t_in + chg;
        end
      end
    end
  end

  assign out_nanoseconds = rns[29:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      count       <= '0;
      prev_off    <= 8'sd0;
      match_found <= 1'b0;
      stat_found  <= 1'b0;
      dbl         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            act   <= action;
            t_in  <= seconds;
            ns_in <= nanoseconds;
            if (is_load) begin
              if (fits) begin
                count    <= cnt_eff + 1'b1;
                prev_off <= leap_offset;
              end
              out_seconds    <= '0;
              rns            <= '0;
              leap_state     <= lstc_pkg::LS_NONE;
              time_status    <= lstc_pkg::ST_OK;
              table_overflow <= !fits;
              done           <= 1'b1;
            end else if (action == lstc_pkg::ACT_R2P || action == lstc_pkg::ACT_P2R) begin
              match_found <= 1'b0;
              stat_found  <= (action == lstc_pkg::ACT_P2R);
              stat_code   <= lstc_pkg::ST_OK;
              cur_idx     <= cnt_m1[lstc_pkg::ADDR_W-1:0];
              state       <= (count == '0) ? S_CALC : S_WALK;
            end else begin
              out_seconds    <= '0;
              rns            <= '0;
              leap_state     <= lstc_pkg::LS_NONE;
              time_status    <= lstc_pkg::ST_OK;
              table_overflow <= 1'b0;
              done           <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (!match_found && verdict.match_hit) begin
            match_found <= 1'b1;
            match_ent   <= cur_ent;
          end
          if (!stat_found && verdict.stat_hit) begin
            stat_found <= 1'b1;
            stat_code  <= verdict.stat_code;
          end
          if (walk_end) begin
            state <= S_CALC;
          end else begin
            cur_idx <= cur_idx - 1'b1;
          end
        end
        S_CALC: begin
          out_seconds    <= calc_sec;
          rns            <= calc_rns;
          leap_state     <= calc_ls;
          time_status    <= fwd ? stat_code : lstc_pkg::ST_OK;
          table_overflow <= 1'b0;
          dbl            <= calc_dbl;
          state          <= S_NORM;
        end
        S_NORM: begin
          // A doubled value carries at most two whole seconds, one per cycle.
          if (dbl && rns >= lstc_pkg::NS_PER_SEC) begin
            rns         <= rns - lstc_pkg::NS_PER_SEC;
            out_seconds <= out_seconds + 32'd1;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever shown after the block has released busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // The table never holds more entries than it has rows.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= lstc_pkg::CNT_W'(lstc_pkg::MAX_LEAPS))
    else $error("entry count beyond table depth");

  // An overflow flag only comes with a load result, whose time fields are zero.
  a_ovf_load: assert property (@(posedge clk) disable iff (rst)
    (done && table_overflow) |-> (out_seconds == '0 && leap_state == lstc_pkg::LS_NONE))
    else $error("overflow flag on a conversion result");

  // Normalization leaves the nanoseconds below one second whenever they were doubled.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (done && dbl && $past(state) == S_NORM) |-> (rns < lstc_pkg::NS_PER_SEC))
    else $error("doubled nanoseconds left unnormalized");

  // A walk always finishes by reaching the result computation.
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && walk_end) |=> (state == S_CALC))
    else $error("walk did not hand over to the result stage");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the leap-second table and right/POSIX time converter.
`default_nettype none

// The bench drives items through the start/busy handshake and keeps its own model of
// the leap table. At the clock edge that accepts an item, the model predicts the
// item's one result and appends it to a queue. The block shows each result for one
// cycle with done high and cannot be stalled. A checker process samples it at the
// edge that ends that cycle and compares it field by field with the oldest queued
// prediction.
//
// The named tests run in this order:
//   - conversions on an empty table, plus an unused action code;
//   - a short hand-built table of one insert and one delete leap, probed at and
//     around each transition, with values near the 32-bit wrap;
//   - filling the table to the brim, dropping loads on a full table, then a restart;
//   - random items up to about 1700 in all, made mostly of well-formed tables probed
//     near their transitions and day starts, with some raw noise mixed in.
module tb;
  import lstc_pkg::*;

  // The one action code the block does not implement.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Cycles allowed after the last result, well above a full table walk.
  localparam int SETTLE_CYCLES = 60;
  // Total item count at which the random test stops sending.
  localparam int RANDOM_ITEMS = 1700;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = ACT_LOAD;
  logic [31:0]        seconds = '0;
  logic [29:0]        nanoseconds = '0;
  logic signed [7:0]  leap_offset = '0;
  logic               restart_table = 1'b0;
  logic               done;
  logic [31:0]        out_seconds;
  logic [29:0]        out_nanoseconds;
  logic signed [2:0]  leap_state;
  logic [2:0]         time_status;
  logic               table_overflow;

  // One result of the block, as the model predicts it.
  typedef struct packed {
    logic [31:0]       secs;
    logic [29:0]       nsec;
    logic signed [2:0] lstate;
    logic [2:0]        status;
    logic              ovf;
  } time_result_t;

  // The model's copy of the leap table. Only entries below leap_count are ever read.
  logic [31:0] leap_transition [MAX_LEAPS];
  logic [31:0] leap_posix      [MAX_LEAPS];
  logic [31:0] leap_day_start  [MAX_LEAPS];
  bit          leap_is_insert  [MAX_LEAPS];
  int          leap_offset_tbl [MAX_LEAPS];
  int          leap_count = 0;
  int          last_offset = 0;

  time_result_t pending_results[$];
  int           error_count = 0;
  int           items_sent = 0;
  int           burst_left = 0;

  always #2 clk = ~clk;

  leap_second_time_converter_top uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .seconds         (seconds),
    .nanoseconds     (nanoseconds),
    .leap_offset     (leap_offset),
    .restart_table   (restart_table),
    .done            (done),
    .out_seconds     (out_seconds),
    .out_nanoseconds (out_nanoseconds),
    .leap_state      (leap_state),
    .time_status     (time_status),
    .table_overflow  (table_overflow)
  );

  // Clock status for a right-time stamp. The newest entry that says anything about
  // t decides. The thresholds one and two seconds past the transition are formed
  // in 64 bits, so they never wrap.
  function automatic logic [2:0] clock_status(input logic [31:0] t);
    longint unsigned tw;
    longint unsigned tr;
    int              k;
    tw = 64'(t);
    for (k = leap_count - 1; k >= 0; k--) begin
      tr = 64'(leap_transition[k]);
      if (leap_is_insert[k]) begin
        if (tw > tr + 2) return ST_OK;
        if (tw > tr + 1) return ST_WAIT;
        if (tw >= tr) return ST_IN_LEAP;
        if (t >= leap_day_start[k]) return ST_INS;
      end else begin
        if (tw > tr + 1) return ST_OK;
        if (tw > tr) return ST_WAIT;
        if (t >= leap_day_start[k]) return ST_DEL;
      end
    end
    return ST_OK;
  endfunction

  // Applies one accepted item to the model's table and returns the result it causes.
  function automatic time_result_t convert_time(input logic [1:0] act,
                                                input logic [31:0] t,
                                                input logic [29:0] ns,
                                                input logic signed [7:0] off,
                                                input logic restart);
    time_result_t      r;
    int                k;
    bit                ins;
    bit                fwd;
    bit                found;
    logic [31:0]       adj;
    logic [31:0]       chg;
    logic [31:0]       rsec;
    logic [31:0]       rns;
    logic signed [2:0] ls;
    r = '0;
    if (act == ACT_LOAD) begin
      if (restart) begin
        leap_count = 0;
        last_offset = 0;
      end
      if (leap_count >= MAX_LEAPS) begin
        r.ovf = 1'b1;
      end else begin
        k = leap_count;
        // An offset that does not grow marks a deleted second.
        ins = int'(off) > last_offset;
        adj = ins ? t - 32'd1 : t;
        leap_is_insert[k] = ins;
        leap_day_start[k] = t - DAY_SECONDS + (ins ? 32'd0 : 32'd1);
        leap_transition[k] = adj;
        leap_posix[k] = adj - 32'(last_offset);
        leap_offset_tbl[k] = int'(off);
        last_offset = int'(off);
        leap_count = k + 1;
      end
    end else if (act == ACT_R2P || act == ACT_P2R) begin
      fwd = (act == ACT_R2P);
      rsec = t;
      rns = 32'(ns);
      ls = LS_NONE;
      found = 1'b0;
      k = leap_count;
      while (k > 0 && !found) begin
        k--;
        if (t >= (fwd ? leap_transition[k] : leap_posix[k])) found = 1'b1;
      end
      if (found) begin
        ins = leap_is_insert[k];
        chg = 32'(leap_offset_tbl[k]);
        if (fwd) begin
          rsec = t - chg;
          if (ins && (t - 32'd1) == leap_transition[k]) begin
            ls = LS_INSERTING;
          end else if (ins && t == leap_transition[k]) begin
            ls = LS_INS_NEXT;
            rsec = rsec + 32'd1;
          end else if (!ins && t == leap_transition[k]) begin
            ls = LS_DEL_NEXT;
            rsec = rsec - 32'd1;
          end
          if (ls == LS_INS_NEXT) begin
            rns = rns >> 1;
          end else if (ls == LS_INSERTING) begin
            rns = (rns + 32'(NS_PER_SEC)) >> 1;
          end else if (ls == LS_DEL_NEXT) begin
            rns = rns << 1;
            while (rns >= 32'(NS_PER_SEC)) begin
              rns = rns - 32'(NS_PER_SEC);
              rsec = rsec + 32'd1;
            end
          end
        end else begin
          rsec = t + chg;
          if (ins && t == leap_posix[k]) begin
            ls = LS_INS_NEXT;
            rsec = rsec - 32'd1;
          end else if (!ins && t == leap_posix[k]) begin
            ls = LS_DEL_NEXT;
            rsec = rsec + 32'd1;
          end else if (!ins && (t - 32'd1) == leap_posix[k]) begin
            ls = LS_DELETED;
          end
          if (ls == LS_INS_NEXT) begin
            rns = rns << 1;
            while (rns >= 32'(NS_PER_SEC)) begin
              rns = rns - 32'(NS_PER_SEC);
              rsec = rsec + 32'd1;
            end
          end else if (ls == LS_DEL_NEXT) begin
            rns = rns >> 1;
          end else if (ls == LS_DELETED) begin
            rns = (rns + 32'(NS_PER_SEC)) >> 1;
          end
        end
      end
      r.secs = rsec;
      r.nsec = rns[29:0];
      r.lstate = ls;
      if (fwd) r.status = clock_status(t);
    end
    return r;
  endfunction

  // Sends one item. The sender first idles for a random number of cycles, unless it
  // is inside a burst. Then it holds start high until the block takes the item, and
  // queues the model's prediction at the edge of acceptance. Start stays high on
  // return, so a back-to-back item needs no extra assignment in the same step.
  task automatic send_item(input logic [1:0] act, input logic [31:0] t,
                           input logic [29:0] ns, input logic signed [7:0] off,
                           input logic restart);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    seconds <= t;
    nanoseconds <= ns;
    leap_offset <= off;
    restart_table <= restart;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(convert_time(act, t, ns, off, restart));
    items_sent++;
  endtask

  // Drops start and waits until every predicted result has come back. The wait always
  // passes a clock edge, so a following item never touches start twice in one step.
  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Nanoseconds for a conversion: mostly in range, with both ends and some values
  // past one second, which the block must also handle.
  function automatic logic [29:0] pick_nanoseconds();
    case ($urandom_range(0, 7))
      0: return 30'd0;
      1: return 30'd999_999_999;
      2: return 30'($urandom_range(1_000_000_000, 30'h3FFF_FFFF));
      default: return 30'($urandom_range(0, 999_999_999));
    endcase
  endfunction

  task automatic report_error(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    error_count++;
    if (error_count <= 10)
      $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endtask

  // Checks every result at the edge that ends its strobe cycle.
  always @(posedge clk) begin
    time_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_error("result with nothing expected", '0, out_seconds);
      end else begin
        want = pending_results.pop_front();
        if (out_seconds !== want.secs)
          report_error("out_seconds", want.secs, out_seconds);
        if (out_nanoseconds !== want.nsec)
          report_error("out_nanoseconds", 32'(want.nsec), 32'(out_nanoseconds));
        if (leap_state !== want.lstate)
          report_error("leap_state", 32'(want.lstate), 32'(leap_state));
        if (time_status !== want.status)
          report_error("time_status", 32'(want.status), 32'(time_status));
        if (table_overflow !== want.ovf)
          report_error("table_overflow", 32'(want.ovf), 32'(table_overflow));
      end
    end
  end

  // With no entries, both directions pass the stamp through untouched, whatever
  // the nanoseconds, and the unused action code returns an all-zero result.
  task automatic test_empty_table();
    send_item(ACT_R2P, 32'd0, 30'd0, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'hFFFF_FFFF, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'd0, 30'h2AAA_AAAA, 8'sd0, 1'b0);
    send_item(ACT_UNUSED, 32'h1234_5678, 30'h1555_5555, -8'sd1, 1'b1);
  endtask

  // One inserted second at 100000, then a deleted one at 200000 with an equal
  // offset. Both are probed on and next to their transitions in both directions.
  // Then come the extreme offsets and a transition at the very top of the range.
  task automatic test_directed_leaps();
    send_item(ACT_LOAD, 32'd100000, 30'd0, 8'sd1, 1'b1);
    // Insert day, before the leap, on the leap, inside it, and while settling.
    send_item(ACT_R2P, 32'd99998, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd99999, 30'd600_000_000, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd100000, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd100001, 30'd1, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd100002, 30'd2, 8'sd0, 1'b0);
    // The inserted second seen from POSIX doubles and carries.
    send_item(ACT_P2R, 32'd99999, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'd100000, 30'd5, 8'sd0, 1'b0);
    // Equal offset: a deleted second.
    send_item(ACT_LOAD, 32'd200000, 30'd0, 8'sd1, 1'b0);
    send_item(ACT_R2P, 32'd200000, 30'h3FFF_FFFF, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd200001, 30'd7, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'd199999, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'd200000, 30'h3FFF_FFFF, 8'sd0, 1'b0);
    // Most negative offset at the last representable second.
    send_item(ACT_LOAD, 32'hFFFF_FFFF, 30'd0, -8'sd128, 1'b0);
    send_item(ACT_R2P, 32'hFFFF_FFFF, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'hFFFF_FFFF, 30'd123, 8'sd0, 1'b0);
    // Largest offset inserted at second zero, so the transition wraps to the top.
    send_item(ACT_LOAD, 32'd0, 30'h3FFF_FFFF, 8'sd127, 1'b1);
    send_item(ACT_R2P, 32'hFFFF_FFFF, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_R2P, 32'd0, 30'd0, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'hFFFF_FFFF, 30'd500_000_000, 8'sd0, 1'b0);
  endtask

  // Fills the table one entry at a time. A conversion then walks the whole table,
  // and loads on the full table are dropped. A restart always makes room again.
  task automatic test_table_overflow();
    int k;
    for (k = 0; k < MAX_LEAPS; k++)
      send_item(ACT_LOAD, 32'd50_000_000 + 32'(k) * 32'd15_000_000, 30'd0,
                8'(k + 1), k == 0);
    send_item(ACT_LOAD, 32'hF000_0000, 30'd0, 8'sd100, 1'b0);
    send_item(ACT_R2P, 32'd50_000_000, 30'd999_999_999, 8'sd0, 1'b0);
    send_item(ACT_P2R, 32'hFFFF_FFF0, 30'd1, 8'sd0, 1'b0);
    send_item(ACT_LOAD, 32'hF000_0001, 30'd0, -8'sd5, 1'b0);
    send_item(ACT_LOAD, 32'd86_400, 30'd0, -8'sd1, 1'b1);
    send_item(ACT_R2P, 32'd86_400, 30'd999_999_999, 8'sd0, 1'b0);
  endtask

  // Random traffic. Most of it builds a fresh table of a few leaps and probes it
  // near the stored transitions and day starts. Now and then a table is grown past
  // its capacity, and raw random items are mixed in as noise. Halfway through, the
  // sender waits for the block to drain completely.
  task automatic test_random_traffic();
    int          n_loads;
    int          n_conv;
    int          k;
    int          idx;
    int          next_off;
    bit          drained;
    logic [31:0] base;
    logic [31:0] t;
    logic [1:0]  act;
    drained = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!drained && items_sent >= RANDOM_ITEMS / 2) begin
        wait_drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          send_item(2'($urandom_range(0, 3)), $urandom, 30'($urandom),
                    8'($urandom), 1'($urandom));
      end else begin
        n_loads = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36)
                                               : $urandom_range(1, 6);
        base = $urandom;
        for (k = 0; k < n_loads; k++) begin
          case ($urandom_range(0, 9))
            6, 7:    next_off = last_offset - 1;
            8:       next_off = last_offset;
            9:       next_off = int'($signed(8'($urandom)));
            default: next_off = last_offset + 1;
          endcase
          send_item(ACT_LOAD, base, pick_nanoseconds(), 8'(next_off),
                    k == 0 && $urandom_range(0, 4) != 0);
          base = base + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(1000, 40_000_000));
        end
        n_conv = $urandom_range(4, 30);
        for (k = 0; k < n_conv; k++) begin
          act = ($urandom_range(0, 1) == 0) ? ACT_R2P : ACT_P2R;
          if (leap_count > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, leap_count - 1);
            case ($urandom_range(0, 3))
              0:       t = leap_transition[idx];
              1:       t = leap_posix[idx];
              2:       t = leap_day_start[idx];
              default: t = leap_transition[idx] + 32'd2;
            endcase
            t = t + 32'($urandom_range(0, 6)) - 32'd3;
          end else begin
            t = $urandom;
          end
          send_item(act, t, pick_nanoseconds(), 8'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed_leaps();
    test_table_overflow();
    test_random_traffic();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard: a correct run finishes in well under a tenth of this time.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
